>>> rtl/lz_token_bit_encoder_core_macros.svh
// Assertion helpers for the LZ token bit encoder.
// Both forms sample on clk_i and are disabled while rst_ni is low.
`ifndef LZ_TOKEN_BIT_ENCODER_CORE_MACROS_SVH
`define LZ_TOKEN_BIT_ENCODER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LZTBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LZTBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define LZTBE_ASSERT(lbl, prop, msg)
`define LZTBE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/lztbe_pkg.sv
package lztbe_pkg;

  typedef enum logic [1:0] {
    CMD_HEADER  = 2'd0,
    CMD_LITERAL = 2'd1,
    CMD_MATCH   = 2'd2,
    CMD_FLUSH   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_RESERVE = 2'd1,
    KIND_FILL    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_LEN  = 2'd1,
    ERR_DIST = 2'd2,
    ERR_RUN  = 2'd3
  } err_e;

  localparam int unsigned MAX_RES        = 5;
  localparam int unsigned RUN_MAX        = 33037;
  localparam int unsigned LEN_LIMIT      = 1034;
  localparam int unsigned DIST_FAR_LIMIT = 4383;
  localparam int unsigned DIST_TWO_LIMIT = 575;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] run_length;
    logic [7:0]  literal_byte;
    logic [10:0] match_length;
    logic [12:0] match_offset;
  } req_t;

  // bit buffer: pending bits left-aligned, count 0..7, reserved-slot flag
  typedef struct packed {
    logic [6:0] bits;
    logic [2:0] cnt;
    logic       slot;
  } bitbuf_t;

  typedef struct packed {
    logic  [MAX_RES-1:0][7:0] bytes;
    kind_e [MAX_RES-1:0]      kinds;
    err_e                     err;
  } job_t;

endpackage

>>> rtl/lztbe_enc.sv
module lztbe_enc (
  input  lztbe_pkg::req_t    req_i,
  input  lztbe_pkg::bitbuf_t buf_i,
  output lztbe_pkg::bitbuf_t buf_o,
  output lztbe_pkg::job_t    job_o,
  output logic [2:0]         job_cnt_o
);

  logic [31:0] code;
  logic [5:0]  code_len;
  lztbe_pkg::err_e err;
  logic        hdr_ok;

  logic [15:0] run, r_m2, r_m5, r_m8, r_m15, r_m270;
  logic [10:0] mlen, m_m4, m_m6, m_m10;
  logic [14:0] mdist, d_p1, d_m63, d_m31, d_m287;
  logic        d_neg, d_low, d_high;
  logic [13:0] lcode, dcode;
  logic [3:0]  llen, dlen;
  logic [31:0] mcode;

  logic [38:0] strm;
  logic [39:0] strm_x;
  logic [5:0]  total;
  logic [2:0]  nbytes;
  logic        slot_after, ph;

  assign run    = req_i.run_length;
  assign r_m2   = run - 16'd2;
  assign r_m5   = run - 16'd5;
  assign r_m8   = run - 16'd8;
  assign r_m15  = run - 16'd15;
  assign r_m270 = run - 16'd270;

  assign mlen  = req_i.match_length;
  assign m_m4  = mlen - 11'd4;
  assign m_m6  = mlen - 11'd6;
  assign m_m10 = mlen - 11'd10;

  assign mdist  = {2'b00, req_i.match_offset} - {4'b0000, mlen};
  assign d_p1   = mdist + 15'd1;
  assign d_m63  = mdist - 15'd63;
  assign d_m31  = mdist - 15'd31;
  assign d_m287 = mdist - 15'd287;
  assign d_neg  = mdist[14];
  // only -1 is allowed among negative distances
  assign d_low  = d_neg && (mdist != 15'h7FFF);
  assign d_high = !d_neg && ((mlen == 11'd2) ? (mdist >= 15'(lztbe_pkg::DIST_TWO_LIMIT))
                                              : (mdist >= 15'(lztbe_pkg::DIST_FAR_LIMIT)));

  // length prefix, left-aligned
  always_comb begin
    if (mlen == 11'd2) begin
      lcode = 14'b0;
      llen  = 4'd1;
    end else if (mlen == 11'd3) begin
      lcode = {2'b10, 12'b0};
      llen  = 4'd2;
    end else if (mlen < 11'd6) begin
      lcode = {3'b110, m_m4[0], 10'b0};
      llen  = 4'd4;
    end else if (mlen < 11'd10) begin
      lcode = {4'b1110, m_m6[1:0], 8'b0};
      llen  = 4'd6;
    end else begin
      lcode = {4'b1111, m_m10[9:0]};
      llen  = 4'd14;
    end
  end

  // distance classes, left-aligned; length 2 has its own
  always_comb begin
    if (mlen == 11'd2) begin
      if (d_neg || mdist < 15'd63) begin
        dcode = {1'b0, d_p1[5:0], 7'b0};
        dlen  = 4'd7;
      end else begin
        dcode = {1'b1, d_m63[8:0], 4'b0};
        dlen  = 4'd10;
      end
    end else begin
      if (d_neg || mdist < 15'd31) begin
        dcode = {2'b10, d_p1[4:0], 7'b0};
        dlen  = 4'd7;
      end else if (mdist < 15'd287) begin
        dcode = {1'b0, d_m31[7:0], 5'b0};
        dlen  = 4'd9;
      end else begin
        dcode = {2'b11, d_m287[11:0]};
        dlen  = 4'd14;
      end
    end
  end

  assign mcode = {lcode, 18'b0} | ({dcode, 18'b0} >> llen);

  always_comb begin
    code     = 32'b0;
    code_len = 6'd0;
    err      = lztbe_pkg::ERR_OK;
    hdr_ok   = 1'b0;
    case (req_i.command)
      lztbe_pkg::CMD_HEADER: begin
        if (run > 16'(lztbe_pkg::RUN_MAX)) begin
          err = lztbe_pkg::ERR_RUN;
        end else if (run == 16'd0) begin
          code_len = 6'd1;
        end else begin
          hdr_ok = 1'b1;
          if (run == 16'd1) begin
            code     = {2'b10, 30'b0};
            code_len = 6'd2;
          end else if (run < 16'd5) begin
            code     = {2'b11, r_m2[1:0], 28'b0};
            code_len = 6'd4;
          end else if (run < 16'd8) begin
            code     = {4'b1111, r_m5[1:0], 26'b0};
            code_len = 6'd6;
          end else if (run < 16'd15) begin
            code     = {6'h3F, r_m8[2:0], 23'b0};
            code_len = 6'd9;
          end else if (run < 16'd270) begin
            code     = {9'h1FF, r_m15[7:0], 15'b0};
            code_len = 6'd17;
          end else begin
            code     = {17'h1FFFF, r_m270[14:0]};
            code_len = 6'd32;
          end
        end
      end
      lztbe_pkg::CMD_MATCH: begin
        if (mlen < 11'd2 || mlen >= 11'(lztbe_pkg::LEN_LIMIT)) begin
          err = lztbe_pkg::ERR_LEN;
        end else if (d_low || d_high) begin
          err = lztbe_pkg::ERR_DIST;
        end else begin
          code     = mcode;
          code_len = 6'({2'b00, llen} + {2'b00, dlen});
        end
      end
      lztbe_pkg::CMD_FLUSH: begin
        code_len = 6'd7;
      end
      default: ;  // literal: bit buffer untouched
    endcase
  end

  // pending bits followed by the new code, MSB-first
  assign strm   = {buf_i.bits, 32'b0} | ({code, 7'b0} >> buf_i.cnt);
  assign strm_x = {strm, 1'b0};
  assign total  = {3'b000, buf_i.cnt} + code_len;
  assign nbytes = total[5:3];

  assign slot_after = buf_i.slot && (nbytes == 3'd0);
  assign ph         = hdr_ok && (total[2:0] != 3'd0) && !slot_after;

  always_comb begin
    buf_o.cnt  = total[2:0];
    buf_o.slot = slot_after || ph;
    case (nbytes)
      3'd0:    buf_o.bits = strm[38:32];
      3'd1:    buf_o.bits = strm[30:24];
      3'd2:    buf_o.bits = strm[22:16];
      3'd3:    buf_o.bits = strm[14:8];
      default: buf_o.bits = strm[6:0];
    endcase
  end

  always_comb begin
    job_o.err = err;
    for (int i = 0; i < lztbe_pkg::MAX_RES; i++) begin
      if (3'(i) < nbytes) begin
        job_o.bytes[i] = strm_x[39 - 8*i -: 8];
        job_o.kinds[i] = (i == 0 && buf_i.slot) ? lztbe_pkg::KIND_FILL
                                                : lztbe_pkg::KIND_APPEND;
      end else if (3'(i) == nbytes && ph) begin
        job_o.bytes[i] = 8'h00;
        job_o.kinds[i] = lztbe_pkg::KIND_RESERVE;
      end else begin
        job_o.bytes[i] = 8'h00;
        job_o.kinds[i] = lztbe_pkg::KIND_NONE;
      end
    end
    job_cnt_o = nbytes + {2'b00, ph};
    if (job_cnt_o == 3'd0) begin
      job_cnt_o = 3'd1;
    end
    if (req_i.command == lztbe_pkg::CMD_LITERAL) begin
      job_o.bytes[0] = req_i.literal_byte;
      job_o.kinds[0] = lztbe_pkg::KIND_APPEND;
    end
  end

endmodule

>>> rtl/lz_token_bit_encoder_core.sv
// LZ token bit encoder.
// Input channel (in_valid_i/in_ready_o) takes one token per request: a
// literal-run header, a literal byte, a match or a flush. Output channel
// (out_valid_o/out_ready_i) gives the resulting bytes in write order, each
// with its slot kind and error code; last_o marks the final result of a
// token. A token that completes no byte still gives one "no byte" result.
// Tokens go into an input register; the encoder turns one into a list of
// up to five results and loads them into the result register once it is
// free, so the first result passes through the input register and then
// the result register. Results leave one per cycle while out_ready_i is
// high; a token occupies the result register until all of its results
// (1 to 5) are taken. The next token waits in the input register and
// loads as the last result of the current one is taken, so single-result
// tokens flow at one per cycle while out_ready_i stays high.
// A stalled receiver holds the current result; the input register still
// takes one more token before in_ready_o drops.
// Reset empties both registers, sets the bit buffer to one pending set
// bit and clears the reserved-slot flag.
`include "lz_token_bit_encoder_core_macros.svh"

module lz_token_bit_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] run_length_i,
  input  logic [7:0]  literal_byte_i,
  input  logic [10:0] match_length_i,
  input  logic [12:0] match_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  slot_kind_o,
  output logic [1:0]  error_code_o,
  output logic        last_o
);

  lztbe_pkg::req_t    req_q;
  logic               req_valid_q;
  lztbe_pkg::bitbuf_t buf_q, buf_d;
  lztbe_pkg::job_t    job_q, job_d;
  logic [2:0]         job_cnt_q, job_cnt_d;
  logic               job_load, in_acc, out_acc;

  assign out_valid_o = (job_cnt_q != 3'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign job_load    = req_valid_q && ((job_cnt_q == 3'd0) || ((job_cnt_q == 3'd1) && out_ready_i));
  assign in_ready_o  = !req_valid_q || job_load;
  assign in_acc      = in_valid_i && in_ready_o;

  lztbe_enc u_enc (
    .req_i     (req_q),
    .buf_i     (buf_q),
    .buf_o     (buf_d),
    .job_o     (job_d),
    .job_cnt_o (job_cnt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      job_cnt_q   <= 3'd0;
      buf_q.bits  <= 7'b1000000;
      buf_q.cnt   <= 3'd1;
      buf_q.slot  <= 1'b0;
    end else begin
      if (in_acc) begin
        req_valid_q <= 1'b1;
      end else if (job_load) begin
        req_valid_q <= 1'b0;
      end
      if (job_load) begin
        job_cnt_q <= job_cnt_d;
        buf_q     <= buf_d;
      end else if (out_acc) begin
        job_cnt_q <= job_cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q.command      <= lztbe_pkg::cmd_e'(command_i);
      req_q.run_length   <= run_length_i;
      req_q.literal_byte <= literal_byte_i;
      req_q.match_length <= match_length_i;
      req_q.match_offset <= match_offset_i;
    end
    if (job_load) begin
      job_q <= job_d;
    end else if (out_acc) begin
      // shift the next result to the head
      for (int i = 0; i < lztbe_pkg::MAX_RES - 1; i++) begin
        job_q.bytes[i] <= job_q.bytes[i+1];
        job_q.kinds[i] <= job_q.kinds[i+1];
      end
    end
  end

  assign out_byte_o   = job_q.bytes[0];
  assign slot_kind_o  = job_q.kinds[0];
  assign error_code_o = job_q.err;
  assign last_o       = (job_cnt_q == 3'd1);

  `LZTBE_ASSERT(a_cnt_bound, job_cnt_q <= 3'(lztbe_pkg::MAX_RES), "result count overflow")
  `LZTBE_ASSERT(a_slot_bits, !buf_q.slot || (buf_q.cnt != 3'd0), "slot reserved on empty buffer")
  `LZTBE_ASSERT_NEXT(a_load_res, job_load, job_cnt_q != 3'd0, "loaded token gave no result")

endmodule

>>> tb/lz_token_bit_encoder_core_tb.sv
module lz_token_bit_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]         data;
    lztbe_pkg::kind_e   kind;
    lztbe_pkg::err_e    err;
    logic               last;
  } coded_t;

  localparam int TIMEOUT_CYCLES = 300000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int N_RANDOM       = 285;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = 2'd0;
  logic [15:0] run_length = 16'd0;
  logic [7:0]  literal_byte = 8'd0;
  logic [10:0] match_length = 11'd0;
  logic [12:0] match_offset = 13'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  slot_kind;
  logic [1:0]  error_code;
  logic        last;

  lztbe_pkg::req_t token_q[$];
  coded_t          coded_bytes_q[$];

  // encoder state mirror
  logic [8:0] bit_acc;
  logic       slot_open;

  logic req_fire = 1'b0;
  int   n_taken = 0;
  int   n_cycles = 0;
  int   fails = 0;
  logic calm;

  // long stretch with no idling on either side
  assign calm = (n_taken >= 100) && (n_taken < 170);

  lz_token_bit_encoder_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .run_length_i   (run_length),
    .literal_byte_i (literal_byte),
    .match_length_i (match_length),
    .match_offset_i (match_offset),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .slot_kind_o    (slot_kind),
    .error_code_o   (error_code),
    .last_o         (last)
  );

  always #6 clk_i = ~clk_i;

  function automatic void add_byte(logic [7:0] d, lztbe_pkg::kind_e k, lztbe_pkg::err_e e);
    coded_t c;
    c.data = d;
    c.kind = k;
    c.err  = e;
    c.last = 1'b0;
    coded_bytes_q.push_back(c);
  endfunction

  function automatic void shift_in_bit(logic b);
    bit_acc = {bit_acc[7:0], b};
    if (bit_acc[8]) begin
      if (slot_open) begin
        add_byte(bit_acc[7:0], lztbe_pkg::KIND_FILL, lztbe_pkg::ERR_OK);
        slot_open = 1'b0;
      end else begin
        add_byte(bit_acc[7:0], lztbe_pkg::KIND_APPEND, lztbe_pkg::ERR_OK);
      end
      bit_acc = 9'd1;
    end
  endfunction

  function automatic void shift_in_bits(int n, int v);
    for (int i = n - 1; i >= 0; i--) shift_in_bit(v[i]);
  endfunction

  // Bytes one token produces, appended to coded_bytes_q in write order.
  function automatic void encode_token(lztbe_pkg::cmd_e cmd, logic [15:0] run, logic [7:0] lit,
                                       logic [10:0] mlen, logic [12:0] moff);
    int n0;
    int len;
    int mdist;
    int lim;
    n0 = coded_bytes_q.size();
    case (cmd)
      lztbe_pkg::CMD_HEADER: begin
        len = int'(run);
        if (len > int'(lztbe_pkg::RUN_MAX)) begin
          add_byte(8'd0, lztbe_pkg::KIND_NONE, lztbe_pkg::ERR_RUN);
        end else if (len == 0) begin
          shift_in_bit(1'b0);
        end else begin
          shift_in_bit(1'b1);
          if (len < 2) begin
            shift_in_bits(1, 0);
          end else if (len < 5) begin
            shift_in_bits(1, 1);
            shift_in_bits(2, len - 2);
          end else if (len < 8) begin
            shift_in_bits(3, 7);
            shift_in_bits(2, len - 5);
          end else if (len < 15) begin
            shift_in_bits(5, 31);
            shift_in_bits(3, len - 8);
          end else if (len < 270) begin
            shift_in_bits(8, 255);
            shift_in_bits(8, len - 15);
          end else begin
            shift_in_bits(8, 255);
            shift_in_bits(8, 255);
            shift_in_bits(15, len - 270);
          end
          // reserve a slot unless one is open or the buffer is empty
          if (bit_acc != 9'd1 && !slot_open) begin
            slot_open = 1'b1;
            add_byte(8'd0, lztbe_pkg::KIND_RESERVE, lztbe_pkg::ERR_OK);
          end
        end
      end
      lztbe_pkg::CMD_LITERAL: add_byte(lit, lztbe_pkg::KIND_APPEND, lztbe_pkg::ERR_OK);
      lztbe_pkg::CMD_MATCH: begin
        len   = int'(mlen);
        mdist = int'(moff) - len;
        lim   = (len == 2) ? int'(lztbe_pkg::DIST_TWO_LIMIT) : int'(lztbe_pkg::DIST_FAR_LIMIT);
        if (len < 2 || len >= int'(lztbe_pkg::LEN_LIMIT)) begin
          add_byte(8'd0, lztbe_pkg::KIND_NONE, lztbe_pkg::ERR_LEN);
        end else if (mdist < -1 || mdist >= lim) begin
          add_byte(8'd0, lztbe_pkg::KIND_NONE, lztbe_pkg::ERR_DIST);
        end else begin
          if (len < 3) begin
            shift_in_bit(1'b0);
          end else if (len < 4) begin
            shift_in_bits(2, 2);
          end else if (len < 6) begin
            shift_in_bits(3, 6);
            shift_in_bits(1, len - 4);
          end else if (len < 10) begin
            shift_in_bits(4, 14);
            shift_in_bits(2, len - 6);
          end else begin
            shift_in_bits(4, 15);
            shift_in_bits(10, len - 10);
          end
          if (len == 2) begin
            if (mdist < 63) begin
              shift_in_bit(1'b0);
              shift_in_bits(6, mdist + 1);
            end else begin
              shift_in_bit(1'b1);
              shift_in_bits(9, mdist - 63);
            end
          end else if (mdist < 31) begin
            shift_in_bits(2, 2);
            shift_in_bits(5, mdist + 1);
          end else if (mdist < 287) begin
            shift_in_bit(1'b0);
            shift_in_bits(8, mdist - 31);
          end else begin
            shift_in_bits(2, 3);
            shift_in_bits(12, mdist - 287);
          end
        end
      end
      default: shift_in_bits(7, 0);
    endcase
    if (coded_bytes_q.size() == n0) add_byte(8'd0, lztbe_pkg::KIND_NONE, lztbe_pkg::ERR_OK);
    coded_bytes_q[coded_bytes_q.size() - 1].last = 1'b1;
  endfunction

  // random base, relevant fields overridden
  function automatic lztbe_pkg::req_t shape_token(lztbe_pkg::cmd_e c, int a, int b);
    lztbe_pkg::req_t t;
    t.command      = c;
    t.run_length   = 16'($urandom);
    t.literal_byte = 8'($urandom);
    t.match_length = 11'($urandom);
    t.match_offset = 13'($urandom);
    case (c)
      lztbe_pkg::CMD_HEADER:  t.run_length = 16'(a);
      lztbe_pkg::CMD_LITERAL: t.literal_byte = 8'(a);
      lztbe_pkg::CMD_MATCH: begin
        t.match_length = 11'(a);
        t.match_offset = 13'(b);
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic lztbe_pkg::req_t draw_token();
    int p;
    int r;
    int len;
    int mdist;
    lztbe_pkg::req_t t;
    p = $urandom_range(99);
    r = $urandom_range(99);
    if (p < 5) begin
      t = shape_token(lztbe_pkg::cmd_e'($urandom_range(3)), 0, 0);
      t.run_length   = 16'($urandom);
      t.literal_byte = 8'($urandom);
      t.match_length = 11'($urandom);
      t.match_offset = 13'($urandom);
    end else if (p < 27) begin
      if (r < 55)      len = $urandom_range(14, 0);
      else if (r < 80) len = $urandom_range(269, 15);
      else if (r < 96) len = $urandom_range(int'(lztbe_pkg::RUN_MAX), 270);
      else             len = $urandom_range(65535, int'(lztbe_pkg::RUN_MAX) + 1);
      t = shape_token(lztbe_pkg::CMD_HEADER, len, 0);
    end else if (p < 52) begin
      t = shape_token(lztbe_pkg::CMD_LITERAL, $urandom_range(255), 0);
    end else if (p < 90) begin
      if ($urandom_range(99) < 30)      len = 2;
      else if ($urandom_range(99) < 70) len = $urandom_range(9, 3);
      else                              len = $urandom_range(1033, 10);
      if (r < 3) begin
        t = shape_token(lztbe_pkg::CMD_MATCH, ($urandom_range(1)) ? $urandom_range(1) :
                        $urandom_range(2047, 1034), $urandom_range(8191));
      end else if (r < 8) begin
        if ($urandom_range(1)) begin
          t = shape_token(lztbe_pkg::CMD_MATCH, len, $urandom_range(len - 2, 0));
        end else begin
          mdist = (len == 2) ? int'(lztbe_pkg::DIST_TWO_LIMIT)
                             : int'(lztbe_pkg::DIST_FAR_LIMIT);
          t = shape_token(lztbe_pkg::CMD_MATCH, len, $urandom_range(8191, len + mdist));
        end
      end else begin
        if (len == 2)      mdist = $urandom_range(int'(lztbe_pkg::DIST_TWO_LIMIT), 0) - 1;
        else if (r < 45)   mdist = $urandom_range(31, 0) - 1;
        else if (r < 75)   mdist = $urandom_range(286, 31);
        else               mdist = $urandom_range(int'(lztbe_pkg::DIST_FAR_LIMIT) - 1, 287);
        t = shape_token(lztbe_pkg::CMD_MATCH, len, len + mdist);
      end
    end else begin
      t = shape_token(lztbe_pkg::CMD_FLUSH, 0, 0);
    end
    return t;
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (token_q.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
        lztbe_pkg::req_t t;
        t = token_q.pop_front();
        in_valid     <= 1'b1;
        command      <= t.command;
        run_length   <= t.run_length;
        literal_byte <= t.literal_byte;
        match_length <= t.match_length;
        match_offset <= t.match_offset;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 15);
  end

  // monitor: predict on request, check on result
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (!rst_ni) begin
      req_fire  <= 1'b0;
      bit_acc   = 9'd3;
      slot_open = 1'b0;
    end else begin
      req_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        encode_token(lztbe_pkg::cmd_e'(command), run_length, literal_byte, match_length,
                     match_offset);
        n_taken <= n_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (coded_bytes_q.size() == 0) begin
          $error("unexpected result: out_byte %0h slot_kind %0d error_code %0d last %0b",
                 out_byte, slot_kind, error_code, last);
          fails++;
        end else begin
          coded_t c;
          c = coded_bytes_q.pop_front();
          if (out_byte !== c.data) begin
            $error("out_byte: expected %0h, got %0h", c.data, out_byte);
            fails++;
          end
          if (slot_kind !== c.kind) begin
            $error("slot_kind: expected %0d, got %0d", c.kind, slot_kind);
            fails++;
          end
          if (error_code !== c.err) begin
            $error("error_code: expected %0d, got %0d", c.err, error_code);
            fails++;
          end
          if (last !== c.last) begin
            $error("last: expected %0b, got %0b", c.last, last);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (n_cycles > TIMEOUT_CYCLES) begin
      $display("lz_token_bit_encoder_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    // directed: header classes, run limit, literal extremes, match limits
    token_q.push_back(shape_token(lztbe_pkg::CMD_HEADER, 0, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_HEADER, 1, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_HEADER, 3, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_HEADER, 6, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_HEADER, 14, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_HEADER, 200, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_HEADER, int'(lztbe_pkg::RUN_MAX), 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_HEADER, int'(lztbe_pkg::RUN_MAX) + 1, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_HEADER, 65535, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_HEADER, 270, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_LITERAL, 0, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_LITERAL, 255, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 0, 100));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 1, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 1034, 2000));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 2047, 8191));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 2, 1));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 2, 0));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 2, 576));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 2, 577));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 3, 2));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 9, 295));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 1033, 5415));
    token_q.push_back(shape_token(lztbe_pkg::CMD_MATCH, 10, 4393));
    token_q.push_back(shape_token(lztbe_pkg::CMD_FLUSH, 0, 0));
    for (int i = 0; i < N_RANDOM; i++) token_q.push_back(draw_token());

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (token_q.size() != 0 || in_valid || coded_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fails == 0) begin
      $display("lz_token_bit_encoder_core_tb: PASS");
    end else begin
      $display("lz_token_bit_encoder_core_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> lz_token_bit_encoder_core.f
+incdir+rtl
rtl/lztbe_pkg.sv
rtl/lztbe_enc.sv
rtl/lz_token_bit_encoder_core.sv
tb/lz_token_bit_encoder_core_tb.sv
